### rtl/core/anf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// anf_pkg
// Types and constants shared by the ALU and its checker.
// ----------------------------------------------------------------------------
package anf_pkg;

    localparam int unsigned DATA_WIDTH = 32;
    localparam int unsigned OP_WIDTH   = 5;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_ADDS = 5'd0,
        OP_ADD  = 5'd1,
        OP_SUBS = 5'd2,
        OP_SUB  = 5'd3,
        OP_ANDS = 5'd4,
        OP_ORRS = 5'd5,
        OP_MOVS = 5'd6,
        OP_MOV  = 5'd7,
        OP_BICS = 5'd8,
        OP_EORS = 5'd9,
        OP_MVNS = 5'd10,
        OP_NOP  = 5'd11,
        OP_CMN  = 5'd12,
        OP_CMP  = 5'd13,
        OP_TST  = 5'd14,
        OP_ADCS = 5'd15,
        OP_SBCS = 5'd16,
        OP_RSBS = 5'd17,
        OP_MULS = 5'd18
    } t_alu_op;

    typedef logic [DATA_WIDTH-1:0] t_word;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } t_flags;

endpackage
`default_nettype wire

### rtl/core/alu_with_nzcv_flags.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alu_with_nzcv_flags
// 32-bit ALU with N, Z, C and V condition flags kept across transactions.
// ----------------------------------------------------------------------------
// Each transaction is registered at the input, evaluated in a single pass
// through one shared adder, a 32 by 32 multiplier and the logic unit, and
// registered at the output; a new transaction can be accepted every cycle
// while the input side is not stalled. The flag register is updated in the
// same cycle as the output register, so an ADCS or SBCS right behind a
// flag-setting operation sees its carry without delay.
// The input side stalls only while the input register holds a transaction
// and the output register holds a result that is itself stalled.
module alu_with_nzcv_flags (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [4:0]            i_action,
    input  wire anf_pkg::t_word        i_operand_m,
    input  wire anf_pkg::t_word        i_operand_n,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output anf_pkg::t_word             o_result_value,
    output logic                       o_write_back,
    output logic                       o_negative_out,
    output logic                       o_zero_out,
    output logic                       o_carry_out,
    output logic                       o_overflow_out
);
    import anf_pkg::*;

    logic               r_in_vld;
    logic [OP_WIDTH-1:0] r_action;
    t_word              r_m;
    t_word              r_n;

    logic               r_out_vld;
    t_word              r_result;
    logic               r_wb;
    t_flags             r_out_flags;
    t_flags             r_flags;

    logic               w_out_free;
    logic               w_advance;
    logic               w_accept;

    t_word              w_add_a;
    t_word              w_add_b;
    logic               w_add_cin;
    logic [DATA_WIDTH:0] w_sum;
    t_word              w_prod;

    t_word              n_result;
    logic               n_wb;
    t_flags             n_flags;
    logic               w_set_nz;
    logic               w_set_cv;

    assign w_out_free = !r_out_vld || !i_stall;
    assign w_advance  = r_in_vld && w_out_free;
    assign o_stall    = r_in_vld && !w_out_free;
    assign w_accept   = i_valid && !o_stall;

    always_comb begin
        w_add_a   = r_m;
        w_add_b   = r_n;
        w_add_cin = 1'b0;
        unique case (r_action)
            OP_SUBS, OP_SUB, OP_CMP: begin
                w_add_b   = ~r_n;
                w_add_cin = 1'b1;
            end
            OP_ADCS: begin
                w_add_cin = r_flags.c;
            end
            OP_SBCS: begin
                w_add_b   = ~r_n;
                w_add_cin = r_flags.c;
            end
            OP_RSBS: begin
                w_add_a   = '0;
                w_add_b   = ~r_m;
                w_add_cin = 1'b1;
            end
            default: begin
                w_add_cin = 1'b0;
            end
        endcase
    end

    assign w_sum  = {1'b0, w_add_a} + {1'b0, w_add_b} + {{DATA_WIDTH{1'b0}}, w_add_cin};
    assign w_prod = r_m * r_n;

    always_comb begin
        n_result = '0;
        n_wb     = 1'b1;
        w_set_nz = 1'b0;
        w_set_cv = 1'b0;
        unique case (r_action)
            OP_ADDS, OP_SUBS, OP_ADCS, OP_SBCS, OP_RSBS: begin
                n_result = w_sum[DATA_WIDTH-1:0];
                w_set_nz = 1'b1;
                w_set_cv = 1'b1;
            end
            OP_CMN, OP_CMP: begin
                n_result = w_sum[DATA_WIDTH-1:0];
                n_wb     = 1'b0;
                w_set_nz = 1'b1;
                w_set_cv = 1'b1;
            end
            OP_ADD, OP_SUB: begin
                n_result = w_sum[DATA_WIDTH-1:0];
            end
            OP_ANDS: begin
                n_result = r_m & r_n;
                w_set_nz = 1'b1;
            end
            OP_TST: begin
                n_result = r_m & r_n;
                n_wb     = 1'b0;
                w_set_nz = 1'b1;
            end
            OP_ORRS: begin
                n_result = r_m | r_n;
                w_set_nz = 1'b1;
            end
            OP_MOVS: begin
                n_result = r_n;
                w_set_nz = 1'b1;
            end
            OP_MOV: begin
                n_result = r_n;
            end
            OP_BICS: begin
                n_result = r_m & ~r_n;
                w_set_nz = 1'b1;
            end
            OP_EORS: begin
                n_result = r_m ^ r_n;
                w_set_nz = 1'b1;
            end
            OP_MVNS: begin
                n_result = ~r_m;
                w_set_nz = 1'b1;
            end
            OP_MULS: begin
                n_result = w_prod;
                w_set_nz = 1'b1;
            end
            default: begin
                n_result = '0;
                n_wb     = 1'b0;
            end
        endcase

        n_flags = r_flags;
        if (w_set_nz) begin
            n_flags.n = n_result[DATA_WIDTH-1];
            n_flags.z = (n_result == '0);
        end
        if (w_set_cv) begin
            n_flags.c = w_sum[DATA_WIDTH];
            n_flags.v = (w_add_a[DATA_WIDTH-1] ^ n_result[DATA_WIDTH-1])
                      & (w_add_b[DATA_WIDTH-1] ^ n_result[DATA_WIDTH-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_flags   <= '0;
        end else begin
            if (w_accept) begin
                r_in_vld <= 1'b1;
            end else if (w_advance) begin
                r_in_vld <= 1'b0;
            end
            if (w_advance) begin
                r_out_vld <= 1'b1;
                r_flags   <= n_flags;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_action;
            r_m      <= i_operand_m;
            r_n      <= i_operand_n;
        end
        if (w_advance) begin
            r_result    <= n_result;
            r_wb        <= n_wb;
            r_out_flags <= n_flags;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_result_value = r_result;
    assign o_write_back   = r_wb;
    assign o_negative_out = r_out_flags.n;
    assign o_zero_out     = r_out_flags.z;
    assign o_carry_out    = r_out_flags.c;
    assign o_overflow_out = r_out_flags.v;

endmodule
`default_nettype wire

### rtl/core/anf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// anf_checker
// Port-level checks of the ALU, attached to the top level by a bind.
// ----------------------------------------------------------------------------
module anf_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_valid,
    input wire logic           o_stall,
    input wire logic [4:0]     i_action,
    input wire anf_pkg::t_word i_operand_m,
    input wire anf_pkg::t_word i_operand_n,
    input wire logic           o_valid,
    input wire logic           i_stall,
    input wire anf_pkg::t_word o_result_value,
    input wire logic           o_write_back,
    input wire logic           o_negative_out,
    input wire logic           o_zero_out,
    input wire logic           o_carry_out,
    input wire logic           o_overflow_out
);
    import anf_pkg::*;

    a_reset_clears_output: assert property (
        @(posedge i_clk) !i_rst_n |=> !o_valid
    ) else $error("Output transaction is valid right after reset.");

    a_stalled_result_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_result_value)
            && $stable(o_write_back) && $stable(o_carry_out))
    ) else $error("A stalled result transaction changed.");

    a_stall_only_when_blocked: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall)
    ) else $error("Input stalled while the output side was free.");

    a_nz_exclusive: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_negative_out && o_zero_out)
    ) else $error("N and Z flags are both set.");

endmodule

bind alu_with_nzcv_flags anf_checker u_anf_checker (.*);
`default_nettype wire
